// ===== rtl/hrlt_pkg.sv =====
// Shared package for the heading rate-limited tracker.
// Holds the fixed-point widths, angle constants, CORDIC table and control structs.
// No dependencies.
`timescale 1ns / 1ps

package hrlt_pkg;

    // CORDIC sizing; the table holds twenty arctangent entries.
    localparam int CORDIC_ITERS     = 14;
    localparam int CORDIC_TABLE_LEN = 20;
    localparam int CORDIC_RUN       = (CORDIC_ITERS < CORDIC_TABLE_LEN) ?
                                      CORDIC_ITERS : CORDIC_TABLE_LEN;
    localparam int ITER_W           = $clog2(CORDIC_TABLE_LEN);

    // Datapath widths.
    localparam int VEL_W      = 16;
    localparam int ANG_W      = 16;
    localparam int CX_W       = 32;
    localparam int Z_W        = 28;
    localparam int FRAC_SHIFT = 12;
    localparam int MUL_W      = 17;
    localparam int PROD_W     = 32;
    localparam int RATE_W     = 27;

    // Angle constants in Q4.12 and in the CORDIC angle format (Q.24).
    localparam int ANG_PI     = 12868;
    localparam int ANG_2PI    = 25736;
    localparam int CORDIC_PI  = 52707179;
    localparam int ROUND_HALF = 2048;

    // Configuration register file.
    localparam int STEP_LIMIT_W = 13;
    localparam int RATE_LIMIT_W = 15;
    localparam int TICK_RATE_W  = 10;
    localparam int MIN_SPEED_W  = 32;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_IDX_W    = 2;

    localparam logic [STEP_LIMIT_W-1:0] STEP_LIMIT_RST = 13'd129;
    localparam logic [RATE_LIMIT_W-1:0] RATE_LIMIT_RST = 15'd6434;
    localparam logic [TICK_RATE_W-1:0]  TICK_RATE_RST  = 10'd50;
    localparam logic [MIN_SPEED_W-1:0]  MIN_SPEED_RST  = 32'd655;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_LIMIT = 2'd0,
        CFG_RATE_LIMIT = 2'd1,
        CFG_TICK_RATE  = 2'd2,
        CFG_MIN_SPEED  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [STEP_LIMIT_W-1:0] step_limit;
        logic [RATE_LIMIT_W-1:0] rate_limit;
        logic [TICK_RATE_W-1:0]  tick_rate;
        logic [MIN_SPEED_W-1:0]  min_speed_sq;
    } cfg_t;

    // Sequencer commands for the CORDIC unit.
    typedef struct packed {
        logic              load;
        logic              step;
        logic [ITER_W-1:0] idx;
    } cordic_ctrl_t;

    // Arctangent of 2^-i in Q.24.
    function automatic logic signed [Z_W-1:0] atan_entry(input logic [ITER_W-1:0] idx);
        logic signed [Z_W-1:0] val;
        case (idx)
            5'd0:    val = 28'sd13176795;
            5'd1:    val = 28'sd7778716;
            5'd2:    val = 28'sd4110060;
            5'd3:    val = 28'sd2086331;
            5'd4:    val = 28'sd1047214;
            5'd5:    val = 28'sd524117;
            5'd6:    val = 28'sd262123;
            5'd7:    val = 28'sd131069;
            5'd8:    val = 28'sd65536;
            5'd9:    val = 28'sd32768;
            5'd10:   val = 28'sd16384;
            5'd11:   val = 28'sd8192;
            5'd12:   val = 28'sd4096;
            5'd13:   val = 28'sd2048;
            5'd14:   val = 28'sd1024;
            5'd15:   val = 28'sd512;
            5'd16:   val = 28'sd256;
            5'd17:   val = 28'sd128;
            5'd18:   val = 28'sd64;
            5'd19:   val = 28'sd32;
            default: val = '0;
        endcase
        return val;
    endfunction

    // Wrap an angle that lies within three half-turns of zero into [-pi, pi).
    function automatic logic signed [ANG_W-1:0] wrap_angle(input logic signed [ANG_W+1:0] a);
        logic signed [ANG_W+1:0] w;
        if (a >= 18'(ANG_PI)) begin
            w = a - 18'(ANG_2PI);
        end else if (a < -18'(ANG_PI)) begin
            w = a + 18'(ANG_2PI);
        end else begin
            w = a;
        end
        return w[ANG_W-1:0];
    endfunction

endpackage

// ===== rtl/hrlt_cfg_regs.sv =====
// Configuration register file for the heading tracker.
// Four write-only registers with their reset values; depends on hrlt_pkg.
`timescale 1ns / 1ps

module hrlt_cfg_regs import hrlt_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index and replace the addressed field.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_idx_t'(cfg_idx))
                CFG_STEP_LIMIT: cfg_next.step_limit   = cfg_wdata[STEP_LIMIT_W-1:0];
                CFG_RATE_LIMIT: cfg_next.rate_limit   = cfg_wdata[RATE_LIMIT_W-1:0];
                CFG_TICK_RATE:  cfg_next.tick_rate    = cfg_wdata[TICK_RATE_W-1:0];
                CFG_MIN_SPEED:  cfg_next.min_speed_sq = cfg_wdata[MIN_SPEED_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_limit   <= STEP_LIMIT_RST;
            cfg_reg.rate_limit   <= RATE_LIMIT_RST;
            cfg_reg.tick_rate    <= TICK_RATE_RST;
            cfg_reg.min_speed_sq <= MIN_SPEED_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/hrlt_cordic.sv =====
// Iterative vectoring CORDIC that finds atan2(vel_y, vel_x).
// One shift-and-add micro-rotation per step under sequencer control; depends on hrlt_pkg.
`timescale 1ns / 1ps

module hrlt_cordic import hrlt_pkg::*; (
    input  logic                     aclk,
    input  cordic_ctrl_t             ctrl,
    input  logic signed [VEL_W-1:0]  vel_x,
    input  logic signed [VEL_W-1:0]  vel_y,
    output logic signed [Z_W-1:0]    angle
);

    logic signed [CX_W-1:0] cx_reg, cx_next;
    logic signed [CX_W-1:0] cy_reg, cy_next;
    logic signed [Z_W-1:0]  z_reg,  z_next;

    logic signed [CX_W-1:0] x_scaled;
    logic signed [CX_W-1:0] y_scaled;
    logic signed [CX_W-1:0] dx;
    logic signed [CX_W-1:0] dy;
    logic                   rot_neg;

    // Scale the velocity by 2^12 into the wide working format.
    assign x_scaled = {{(CX_W-VEL_W-FRAC_SHIFT){vel_x[VEL_W-1]}}, vel_x, {FRAC_SHIFT{1'b0}}};
    assign y_scaled = {{(CX_W-VEL_W-FRAC_SHIFT){vel_y[VEL_W-1]}}, vel_y, {FRAC_SHIFT{1'b0}}};

    // Shared barrel shifter and the rotation direction from the sign of y.
    assign dx      = cx_reg >>> ctrl.idx;
    assign dy      = cy_reg >>> ctrl.idx;
    assign rot_neg = cy_reg[CX_W-1] || (cy_reg == '0);

    always_comb begin
        cx_next = cx_reg;
        cy_next = cy_reg;
        z_next  = z_reg;
        if (ctrl.load) begin
            // Vectors in the left half-plane are turned by a half-turn first.
            if (vel_x[VEL_W-1]) begin
                cx_next = -x_scaled;
                cy_next = -y_scaled;
                z_next  = vel_y[VEL_W-1] ? -Z_W'(CORDIC_PI) : Z_W'(CORDIC_PI);
            end else begin
                cx_next = x_scaled;
                cy_next = y_scaled;
                z_next  = '0;
            end
        end else if (ctrl.step) begin
            if (rot_neg) begin
                cx_next = cx_reg - dy;
                cy_next = cy_reg + dx;
                z_next  = z_reg - atan_entry(ctrl.idx);
            end else begin
                cx_next = cx_reg + dy;
                cy_next = cy_reg - dx;
                z_next  = z_reg + atan_entry(ctrl.idx);
            end
        end
    end

    always_ff @(posedge aclk) begin
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        z_reg  <= z_next;
    end

    assign angle = z_reg;

endmodule

// ===== rtl/heading_rate_limited_tracker_core.sv =====
// Top level of the heading rate-limited tracker: sequencer, shared multiplier and yaw update.
// Uses hrlt_pkg, hrlt_cfg_regs and hrlt_cordic.
// An accepted request passes SQX, SQY, SUM, the ITER loop of the CORDIC, ROUND, DIFF, CLAMP,
// UPD and OUT, which waits for a free output register; the CORDIC loop runs
// one micro-rotation per cycle, and the input is not ready while a request is in work.
// Reset: aresetn, synchronous, clears yaw and rate state and restores the register defaults.
`timescale 1ns / 1ps

module heading_rate_limited_tracker_core import hrlt_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_idx,
    input  logic [CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [VEL_W-1:0]  s_vel_x,
    input  logic signed [VEL_W-1:0]  s_vel_y,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [ANG_W-1:0]  m_yaw_cmd,
    output logic signed [ANG_W-1:0]  m_yaw_rate_cmd
);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_SQX   = 10'b0000000010,
        ST_SQY   = 10'b0000000100,
        ST_SUM   = 10'b0000001000,
        ST_ITER  = 10'b0000010000,
        ST_ROUND = 10'b0000100000,
        ST_DIFF  = 10'b0001000000,
        ST_CLAMP = 10'b0010000000,
        ST_UPD   = 10'b0100000000,
        ST_OUT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic [ITER_W-1:0] iter_reg, iter_next;

    logic signed [VEL_W-1:0]  vx_reg, vx_next;
    logic signed [VEL_W-1:0]  vy_reg, vy_next;
    logic signed [PROD_W-1:0] mul_reg, mul_next;
    logic [MIN_SPEED_W-1:0]   spd_reg, spd_next;
    logic signed [ANG_W-1:0]  tgt_reg, tgt_next;
    logic signed [ANG_W-1:0]  d_reg, d_next;
    logic signed [ANG_W-1:0]  dc_reg, dc_next;
    logic                     clamp_pos_reg, clamp_pos_next;
    logic                     clamp_neg_reg, clamp_neg_next;
    logic signed [ANG_W-1:0]  prev_yaw_reg, prev_yaw_next;
    logic signed [ANG_W-1:0]  prev_rate_reg, prev_rate_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [ANG_W-1:0]  yaw_out_reg, yaw_out_next;
    logic signed [ANG_W-1:0]  rate_out_reg, rate_out_next;

    cfg_t                     cfg;
    cordic_ctrl_t             cordic_ctrl;
    logic signed [Z_W-1:0]    angle;

    logic signed [MUL_W-1:0]    mul_a;
    logic signed [MUL_W-1:0]    mul_b;
    logic signed [2*MUL_W-1:0]  mul_p;
    logic signed [Z_W-1:0]      z_round;
    logic                       slow;
    logic signed [ANG_W+1:0]    diff_raw;
    logic signed [ANG_W:0]      d_ext;
    logic signed [ANG_W:0]      lim_ext;
    logic signed [ANG_W+1:0]    yaw_sum;
    logic signed [RATE_W-1:0]   new_rate;
    logic signed [RATE_W-1:0]   rate_sum;
    logic signed [RATE_W-1:0]   rate_avg;
    logic signed [ANG_W-1:0]    rate_sat;
    logic                       accept;
    logic                       out_free;

    hrlt_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    hrlt_cordic u_cordic (
        .aclk  (aclk),
        .ctrl  (cordic_ctrl),
        .vel_x (s_vel_x),
        .vel_y (s_vel_y),
        .angle (angle)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;

    assign cordic_ctrl.load = accept;
    assign cordic_ctrl.step = (state_reg == ST_ITER);
    assign cordic_ctrl.idx  = iter_reg;

    // Shared multiplier: squares of the velocity, then the step times the tick rate.
    always_comb begin
        case (state_reg)
            ST_SQY: begin
                mul_a = {vy_reg[VEL_W-1], vy_reg};
                mul_b = {vy_reg[VEL_W-1], vy_reg};
            end
            ST_CLAMP: begin
                mul_a = {d_reg[ANG_W-1], d_reg};
                mul_b = {{(MUL_W-TICK_RATE_W){1'b0}}, cfg.tick_rate};
            end
            default: begin
                mul_a = {vx_reg[VEL_W-1], vx_reg};
                mul_b = {vx_reg[VEL_W-1], vx_reg};
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Target selection and heading difference.
    assign z_round  = angle + Z_W'(ROUND_HALF);
    assign slow     = (spd_reg <= cfg.min_speed_sq);
    assign diff_raw = {{2{tgt_reg[ANG_W-1]}}, tgt_reg} - {{2{prev_yaw_reg[ANG_W-1]}}, prev_yaw_reg};

    // Step limit compare.
    assign d_ext   = {d_reg[ANG_W-1], d_reg};
    assign lim_ext = {{(ANG_W+1-STEP_LIMIT_W){1'b0}}, cfg.step_limit};

    // New yaw and averaged, saturated rate.
    assign yaw_sum = {{2{prev_yaw_reg[ANG_W-1]}}, prev_yaw_reg} + {{2{dc_reg[ANG_W-1]}}, dc_reg};

    always_comb begin
        if (clamp_pos_reg) begin
            new_rate = {{(RATE_W-RATE_LIMIT_W){1'b0}}, cfg.rate_limit};
        end else if (clamp_neg_reg) begin
            new_rate = -{{(RATE_W-RATE_LIMIT_W){1'b0}}, cfg.rate_limit};
        end else begin
            new_rate = mul_reg[RATE_W-1:0];
        end
    end

    assign rate_sum = {{(RATE_W-ANG_W){prev_rate_reg[ANG_W-1]}}, prev_rate_reg} + new_rate;
    assign rate_avg = rate_sum >>> 1;

    always_comb begin
        if (rate_avg > RATE_W'(32767)) begin
            rate_sat = 16'sh7FFF;
        end else if (rate_avg < -RATE_W'(32768)) begin
            rate_sat = 16'sh8000;
        end else begin
            rate_sat = rate_avg[ANG_W-1:0];
        end
    end

    // Sequencer.
    always_comb begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        vx_next        = vx_reg;
        vy_next        = vy_reg;
        mul_next       = mul_reg;
        spd_next       = spd_reg;
        tgt_next       = tgt_reg;
        d_next         = d_reg;
        dc_next        = dc_reg;
        clamp_pos_next = clamp_pos_reg;
        clamp_neg_next = clamp_neg_reg;
        prev_yaw_next  = prev_yaw_reg;
        prev_rate_next = prev_rate_reg;
        out_valid_next = out_valid_reg && !m_ready;
        yaw_out_next   = yaw_out_reg;
        rate_out_next  = rate_out_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    vx_next    = s_vel_x;
                    vy_next    = s_vel_y;
                    state_next = ST_SQX;
                end
            end
            ST_SQX: begin
                mul_next   = mul_p[PROD_W-1:0];
                state_next = ST_SQY;
            end
            ST_SQY: begin
                spd_next   = mul_reg;
                mul_next   = mul_p[PROD_W-1:0];
                state_next = ST_SUM;
            end
            ST_SUM: begin
                spd_next   = spd_reg + mul_reg;
                iter_next  = '0;
                state_next = ST_ITER;
            end
            ST_ITER: begin
                if (iter_reg == ITER_W'(CORDIC_RUN - 1)) begin
                    state_next = ST_ROUND;
                end else begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            ST_ROUND: begin
                // A slow or zero velocity holds the last heading.
                tgt_next   = slow ? prev_yaw_reg : z_round[FRAC_SHIFT +: ANG_W];
                state_next = ST_DIFF;
            end
            ST_DIFF: begin
                d_next     = wrap_angle(diff_raw);
                state_next = ST_CLAMP;
            end
            ST_CLAMP: begin
                mul_next = mul_p[PROD_W-1:0];
                if (d_ext < -lim_ext) begin
                    dc_next        = -lim_ext[ANG_W-1:0];
                    clamp_pos_next = 1'b0;
                    clamp_neg_next = 1'b1;
                end else if (d_ext > lim_ext) begin
                    dc_next        = lim_ext[ANG_W-1:0];
                    clamp_pos_next = 1'b1;
                    clamp_neg_next = 1'b0;
                end else begin
                    dc_next        = d_reg;
                    clamp_pos_next = 1'b0;
                    clamp_neg_next = 1'b0;
                end
                state_next = ST_UPD;
            end
            ST_UPD: begin
                prev_yaw_next  = wrap_angle(yaw_sum);
                prev_rate_next = rate_sat;
                state_next     = ST_OUT;
            end
            ST_OUT: begin
                // Hand the result to the output register once it is free.
                if (out_free) begin
                    yaw_out_next   = prev_yaw_reg;
                    rate_out_next  = prev_rate_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state and tracker state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            iter_reg      <= '0;
            prev_yaw_reg  <= '0;
            prev_rate_reg <= '0;
            out_valid_reg <= 1'b0;
            clamp_pos_reg <= 1'b0;
            clamp_neg_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            prev_yaw_reg  <= prev_yaw_next;
            prev_rate_reg <= prev_rate_next;
            out_valid_reg <= out_valid_next;
            clamp_pos_reg <= clamp_pos_next;
            clamp_neg_reg <= clamp_neg_next;
        end
    end

    // Working registers of the datapath.
    always_ff @(posedge aclk) begin
        vx_reg       <= vx_next;
        vy_reg       <= vy_next;
        mul_reg      <= mul_next;
        spd_reg      <= spd_next;
        tgt_reg      <= tgt_next;
        d_reg        <= d_next;
        dc_reg       <= dc_next;
        yaw_out_reg  <= yaw_out_next;
        rate_out_reg <= rate_out_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_yaw_cmd      = yaw_out_reg;
    assign m_yaw_rate_cmd = rate_out_reg;

endmodule

// ===== verif/hrlt_tracker_checker.sv =====
// Scoreboard for the heading rate-limited tracker: follows the register writes, predicts
// the yaw command for every accepted velocity request and compares it with the result channel.
// Depends on hrlt_pkg for the port widths and the register index names.
`timescale 1ns / 1ps

module hrlt_tracker_checker import hrlt_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_idx,
    input  logic [CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic signed [VEL_W-1:0]  s_vel_x,
    input  logic signed [VEL_W-1:0]  s_vel_y,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic signed [ANG_W-1:0]  m_yaw_cmd,
    input  logic signed [ANG_W-1:0]  m_yaw_rate_cmd,
    output int                       fail_count,
    output int                       pending
);

    // The rotation count never exceeds the length of the arctangent table.
    localparam int     ROT_STEPS     = (CORDIC_ITERS < 20) ? CORDIC_ITERS : 20;
    localparam longint HALF_TURN_Q24 = 52707179;
    localparam int     HALF_TURN     = 12868;
    localparam int     FULL_TURN     = 25736;
    localparam longint ATAN_Q24[20]  = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32
    };

    typedef struct {
        logic signed [15:0] yaw;
        logic signed [15:0] rate;
    } yaw_cmd_t;

    yaw_cmd_t    yaw_cmd_q[$];
    logic [12:0] step_limit;
    logic [14:0] rate_limit;
    logic [9:0]  tick_rate;
    logic [31:0] min_speed_sq;
    int          yaw_now;
    int          rate_now;
    int          errors = 0;

    assign fail_count = errors;

    // Every mismatch prints one line and is counted.
    task automatic report_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        errors++;
    endtask

    // Wrap an angle into [-pi, pi) in Q4.12.
    function automatic int wrap_half_turn(input int a);
        int m;
        m = (a + HALF_TURN) % FULL_TURN;
        if (m < 0) begin
            m += FULL_TURN;
        end
        return m - HALF_TURN;
    endfunction

    // Direction of the velocity vector by vectoring rotations, rounded to Q4.12.
    function automatic int heading_q12(input int vx, input int vy);
        longint cx;
        longint cy;
        longint z;
        longint dx;
        longint dy;
        cx = longint'(vx) * 4096;
        cy = longint'(vy) * 4096;
        z  = 0;
        // Fold the left half-plane onto the right one first.
        if (cx < 0) begin
            z  = (cy >= 0) ? HALF_TURN_Q24 : -HALF_TURN_Q24;
            cx = -cx;
            cy = -cy;
        end
        for (int i = 0; i < ROT_STEPS; i++) begin
            dx = cx >>> i;
            dy = cy >>> i;
            if (cy > 0) begin
                cx += dy;
                cy -= dx;
                z  += ATAN_Q24[i];
            end else begin
                cx -= dy;
                cy += dx;
                z  -= ATAN_Q24[i];
            end
        end
        return int'((z + 2048) >>> 12);
    endfunction

    // One tracker tick: pick the target, limit the step and smooth the rate.
    task automatic advance_heading(input int vx, input int vy, output yaw_cmd_t cmd);
        longint speed_sq;
        longint new_rate;
        longint avg;
        int     target;
        int     d;
        int     lim;
        speed_sq = longint'(vx) * longint'(vx) + longint'(vy) * longint'(vy);
        // A slow vehicle keeps its heading.
        if (speed_sq <= longint'(min_speed_sq)) begin
            target = yaw_now;
        end else begin
            target = heading_q12(vx, vy);
        end
        lim = int'(step_limit);
        d   = wrap_half_turn(target - yaw_now);
        if (d < -lim) begin
            d        = -lim;
            new_rate = -longint'(rate_limit);
        end else if (d > lim) begin
            d        = lim;
            new_rate = longint'(rate_limit);
        end else begin
            new_rate = longint'(d) * longint'(tick_rate);
        end
        yaw_now = wrap_half_turn(yaw_now + d);
        avg     = (longint'(rate_now) + new_rate) >>> 1;
        if (avg > 32767) begin
            avg = 32767;
        end
        if (avg < -32768) begin
            avg = -32768;
        end
        rate_now = int'(avg);
        cmd.yaw  = yaw_now[15:0];
        cmd.rate = rate_now[15:0];
    endtask

    // Track register writes, predict on each accepted request, compare each result.
    always @(posedge aclk) begin
        yaw_cmd_t want;
        yaw_cmd_t cmd;
        if (!aresetn) begin
            yaw_cmd_q.delete();
            step_limit   = 13'd129;
            rate_limit   = 15'd6434;
            tick_rate    = 10'd50;
            min_speed_sq = 32'd655;
            yaw_now      = 0;
            rate_now     = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_STEP_LIMIT: step_limit   = cfg_wdata[12:0];
                    CFG_RATE_LIMIT: rate_limit   = cfg_wdata[14:0];
                    CFG_TICK_RATE:  tick_rate    = cfg_wdata[9:0];
                    CFG_MIN_SPEED:  min_speed_sq = cfg_wdata[31:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (yaw_cmd_q.size() == 0) begin
                    report_error($sformatf("result yaw %0d rate %0d with no request outstanding",
                                           m_yaw_cmd, m_yaw_rate_cmd));
                end else begin
                    want = yaw_cmd_q.pop_front();
                    if (m_yaw_cmd !== want.yaw) begin
                        report_error($sformatf("yaw_cmd got %0d expected %0d",
                                               m_yaw_cmd, want.yaw));
                    end
                    if (m_yaw_rate_cmd !== want.rate) begin
                        report_error($sformatf("yaw_rate_cmd got %0d expected %0d",
                                               m_yaw_rate_cmd, want.rate));
                    end
                end
            end
            if (s_valid && s_ready) begin
                advance_heading(s_vel_x, s_vel_y, cmd);
                yaw_cmd_q = {yaw_cmd_q, cmd};
            end
        end
        pending <= yaw_cmd_q.size();
    end

endmodule

// ===== verif/heading_rate_limited_tracker_core_tb.sv =====
// Top of the heading rate-limited tracker testbench: clock, reset, register writes, velocity
// requests and result back-pressure; the verdict comes from hrlt_tracker_checker.
// Depends on hrlt_pkg, heading_rate_limited_tracker_core and hrlt_tracker_checker.
`timescale 1ns / 1ps

module heading_rate_limited_tracker_core_tb;
    import hrlt_pkg::*;

    logic                    aclk      = 1'b0;
    logic                    aresetn   = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_idx   = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                    s_valid   = 1'b0;
    logic                    s_ready;
    logic signed [VEL_W-1:0] s_vel_x   = '0;
    logic signed [VEL_W-1:0] s_vel_y   = '0;
    logic                    m_valid;
    logic                    m_ready   = 1'b0;
    logic signed [ANG_W-1:0] m_yaw_cmd;
    logic signed [ANG_W-1:0] m_yaw_rate_cmd;
    int                      fail_count;
    int                      pending;

    // Idle percentages of both sides and the long receiver hold-off trigger.
    int send_idle_pct     = 0;
    int recv_idle_pct     = 0;
    int hold_off_requests = 0;
    int hold_off_seen     = 0;
    int stall_left        = 0;
    int walk_x            = 3000;
    int walk_y            = 0;

    heading_rate_limited_tracker_core u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_idx        (cfg_idx),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_vel_x        (s_vel_x),
        .s_vel_y        (s_vel_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_yaw_cmd      (m_yaw_cmd),
        .m_yaw_rate_cmd (m_yaw_rate_cmd)
    );

    hrlt_tracker_checker u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_idx        (cfg_idx),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_vel_x        (s_vel_x),
        .s_vel_y        (s_vel_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_yaw_cmd      (m_yaw_cmd),
        .m_yaw_rate_cmd (m_yaw_rate_cmd),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #10_000_000;
        $display("heading_rate_limited_tracker_core verification failed");
        $finish;
    end

    // Result side: random back-pressure, plus a long hold-off on request.
    always @(posedge aclk) begin
        if (hold_off_requests != hold_off_seen) begin
            hold_off_seen = hold_off_requests;
            stall_left    = 300;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= (int'($urandom_range(99)) >= recv_idle_pct);
        end
    end

    // Write all four registers on consecutive cycles, starting at the current edge.
    task automatic load_registers(input logic [31:0] stp, input logic [31:0] rl,
                                  input logic [31:0] tr, input logic [31:0] ms);
        cfg_we    <= 1'b1;
        cfg_idx   <= CFG_STEP_LIMIT;
        cfg_wdata <= stp;
        @(posedge aclk);
        cfg_idx   <= CFG_RATE_LIMIT;
        cfg_wdata <= rl;
        @(posedge aclk);
        cfg_idx   <= CFG_TICK_RATE;
        cfg_wdata <= tr;
        @(posedge aclk);
        cfg_idx   <= CFG_MIN_SPEED;
        cfg_wdata <= ms;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Offer one velocity request, with an optional gap before it, and wait for acceptance.
    task automatic send_velocity(input int vx, input int vy);
        int gap;
        gap = 0;
        if (int'($urandom_range(99)) < send_idle_pct) begin
            gap = $urandom_range(1, 30);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_vel_x <= vx[15:0];
        s_vel_y <= vy[15:0];
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (30) @(posedge aclk);
    endtask

    // Mostly a slowly turning velocity, with full-range, near-threshold and edge values.
    task automatic next_velocity(output int vx, output int vy);
        int kind;
        kind = $urandom_range(99);
        if (kind < 25) begin
            vx = int'($urandom_range(65535)) - 32768;
            vy = int'($urandom_range(65535)) - 32768;
        end else if (kind < 40) begin
            vx = int'($urandom_range(80)) - 40;
            vy = int'($urandom_range(80)) - 40;
        end else if (kind < 50) begin
            case ($urandom_range(4))
                0: vx = -32768;
                1: vx = -1;
                2: vx = 0;
                3: vx = 1;
                default: vx = 32767;
            endcase
            case ($urandom_range(4))
                0: vy = -32768;
                1: vy = -1;
                2: vy = 0;
                3: vy = 1;
                default: vy = 32767;
            endcase
        end else begin
            if ($urandom_range(99) < 5) begin
                walk_x = int'($urandom_range(8000)) - 4000;
                walk_y = int'($urandom_range(8000)) - 4000;
            end
            walk_x = walk_x + int'($urandom_range(600)) - 300;
            walk_y = walk_y + int'($urandom_range(600)) - 300;
            if (walk_x > 32767) walk_x = 32767;
            if (walk_x < -32768) walk_x = -32768;
            if (walk_y > 32767) walk_y = 32767;
            if (walk_y < -32768) walk_y = -32768;
            vx = walk_x;
            vy = walk_y;
        end
    endtask

    // Stimulus and verdict.
    initial begin
        int          vx;
        int          vy;
        logic [31:0] stp;
        logic [31:0] rl;
        logic [31:0] tr;
        logic [31:0] ms;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Threshold set so that 25^2 + 5^2 sits exactly on it.
        load_registers(129, 6434, 50, 650);
        send_velocity(0, 0);
        send_velocity(25, 5);
        send_velocity(-5, 25);
        send_velocity(25, 6);
        send_velocity(32767, 0);
        send_velocity(-32768, 0);
        send_velocity(0, 32767);
        send_velocity(0, -32768);
        send_velocity(-32768, -32768);
        send_velocity(32767, 32767);
        send_velocity(-32768, 32767);
        send_velocity(32767, -32768);
        send_velocity(-256, 0);
        send_velocity(-256, -1);
        send_velocity(-256, 1);
        drain_results();

        // Largest step limit: half-turn jumps and a saturating rate.
        load_registers(8191, 0, 1023, 0);
        send_velocity(256, 0);
        send_velocity(-256, 0);
        send_velocity(256, 0);
        drain_results();

        // Unit step with a zero tick rate: steps land on the limit or are clamped.
        load_registers(1, 32767, 0, 0);
        send_velocity(256, 0);
        send_velocity(256, 0);
        send_velocity(256, 16);
        send_velocity(-256, 0);
        drain_results();

        // Zero step limit: the yaw cannot move.
        load_registers(0, 100, 7, 0);
        send_velocity(0, 256);
        send_velocity(0, 0);
        drain_results();

        // Random phases: fixed extreme settings first, then random ones.
        for (int p = 0; p < 9; p++) begin
            case (p / 3)
                0: begin
                    send_idle_pct = 31;
                    recv_idle_pct = 78;
                end
                1: begin
                    send_idle_pct = 78;
                    recv_idle_pct = 31;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            case (p)
                0: load_registers(129, 6434, 50, 655);
                1: load_registers(8191, 32767, 1023, 0);
                2: load_registers(0, 0, 0, 32'hFFFF_FFFF);
                3: load_registers(1, 100, 1000, 65536);
                default: begin
                    if ($urandom_range(1) == 0) begin
                        stp = $urandom_range(0, 300);
                    end else begin
                        stp = $urandom_range(0, 8191);
                    end
                    rl = $urandom_range(0, 32767);
                    tr = $urandom_range(0, 1023);
                    if ($urandom_range(99) < 70) begin
                        ms = $urandom_range(0, 200000);
                    end else begin
                        ms = $urandom;
                    end
                    // Bits above each register width must be ignored.
                    if ($urandom_range(1) == 0) begin
                        stp = stp | (32'($urandom) << 13);
                        rl  = rl | (32'($urandom) << 15);
                        tr  = tr | (32'($urandom) << 10);
                    end
                    load_registers(stp, rl, tr, ms);
                end
            endcase
            if (p == 0 || p == 6) begin
                hold_off_requests++;
            end
            repeat (148) begin
                next_velocity(vx, vy);
                send_velocity(vx, vy);
            end
            drain_results();
        end

        repeat (40) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("heading_rate_limited_tracker_core verification clean");
        end else begin
            $display("heading_rate_limited_tracker_core verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/hrlt_pkg.sv
rtl/hrlt_cfg_regs.sv
rtl/hrlt_cordic.sv
rtl/heading_rate_limited_tracker_core.sv
verif/hrlt_tracker_checker.sv
verif/heading_rate_limited_tracker_core_tb.sv
